// File: design/smt_lib_tokenizer_assert.svh
// Assertion macros for the SMT-LIB2 tokenizer modules.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef SMT_LIB_TOKENIZER_ASSERT_SVH
`define SMT_LIB_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define SLT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("slt assertion failed");
`define SLT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("slt assertion failed");
`define SLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("slt assertion failed");
`else
`define SLT_ASSERT_ALWAYS(lbl, cond)
`define SLT_ASSERT_IMPL(lbl, ante, cons)
`define SLT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/slt_pkg.sv
// Shared types, codes and character classes for the SMT-LIB2 tokenizer.
// No dependencies; used by every module of the block.
package slt_pkg;

    localparam int LINE_BITS_DEF   = 24;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int HDR_BITS        = 17;
    localparam int MAX_EVENTS      = 3;

    typedef enum logic [13:0] {
        M_IDLE    = 14'b00000000000001,
        M_COMMENT = 14'b00000000000010,
        M_SYMBOL  = 14'b00000000000100,
        M_KEYWORD = 14'b00000000001000,
        M_QSYM    = 14'b00000000010000,
        M_STRING  = 14'b00000000100000,
        M_NUM     = 14'b00000001000000,
        M_DEC     = 14'b00000010000000,
        M_HASH    = 14'b00000100000000,
        M_BIN1    = 14'b00001000000000,
        M_BIN     = 14'b00010000000000,
        M_HEX1    = 14'b00100000000000,
        M_HEX     = 14'b01000000000000,
        M_ERROR   = 14'b10000000000000
    } mode_t;

    localparam logic [1:0] EV_START   = 2'd0;
    localparam logic [1:0] EV_CONTENT = 2'd1;
    localparam logic [1:0] EV_END     = 2'd2;
    localparam logic [1:0] EV_ERROR   = 2'd3;

    localparam logic [3:0] KIND_LPAREN  = 4'd0;
    localparam logic [3:0] KIND_RPAREN  = 4'd1;
    localparam logic [3:0] KIND_KEYWORD = 4'd2;
    localparam logic [3:0] KIND_SYMBOL  = 4'd3;
    localparam logic [3:0] KIND_STRING  = 4'd4;
    localparam logic [3:0] KIND_NUMERAL = 4'd5;
    localparam logic [3:0] KIND_BINARY  = 4'd6;
    localparam logic [3:0] KIND_HEX     = 4'd7;
    localparam logic [3:0] KIND_DECIMAL = 4'd8;
    localparam logic [3:0] KIND_EOF     = 4'd9;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_EOF_QSYM = 3'd1;
    localparam logic [2:0] ERR_EOF_STR  = 3'd2;
    localparam logic [2:0] ERR_ESCAPE   = 3'd3;
    localparam logic [2:0] ERR_INVALID  = 3'd4;
    localparam logic [2:0] ERR_RADIX    = 3'd5;

    localparam logic [7:0] CH_EOF    = 8'hFF;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    typedef struct packed {
        logic [1:0] ev;
        logic [3:0] kind;
        logic [7:0] data;
        logic [2:0] err;
    } evt_hdr_t;

    function automatic evt_hdr_t mk_hdr(input logic [1:0] ev, input logic [3:0] kind,
                                        input logic [7:0] data, input logic [2:0] err);
        evt_hdr_t h;
        h.ev   = ev;
        h.kind = kind;
        h.data = data;
        h.err  = err;
        return h;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[CH_ZERO:CH_NINE]});
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[CH_ZERO:CH_NINE], [8'h61:8'h66], [8'h41:8'h46]});
    endfunction

    function automatic logic is_sym(input logic [7:0] c);
        return (c inside {[CH_ZERO:CH_NINE], [8'h61:8'h7A], [8'h41:8'h5A],
                          8'h7E, 8'h21, 8'h40, 8'h24, 8'h25, 8'h5E, 8'h26,
                          8'h2A, 8'h5F, 8'h2D, 8'h2B, 8'h3D, 8'h3C, 8'h3E,
                          CH_DOT, 8'h3F});
    endfunction

endpackage

// File: design/slt_front.sv
// Front end: accepts one byte per cycle while push_ready holds, advances
// the lexer mode and counters, and bundles up to three events. Needs slt_pkg.
`include "smt_lib_tokenizer_assert.svh"
module slt_front
    import slt_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    localparam int EVT_BITS   = HDR_BITS + LINE_BITS + OFFSET_BITS,
    localparam int BUNDLE_BITS = 2 + MAX_EVENTS * EVT_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_data,
    input  logic                   in_eoi,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [BUNDLE_BITS-1:0] push_data
);

    mode_t                   mode_reg, mode_next;
    logic                    esc_reg, esc_next;
    logic [LINE_BITS-1:0]    line_reg, line_next;
    logic [OFFSET_BITS-1:0]  off_reg, off_next;
    logic [LINE_BITS-1:0]    tsl_reg, tsl_next;
    logic [OFFSET_BITS-1:0]  tso_reg, tso_next;

    logic                    eof;
    logic [7:0]              ch;
    logic                    again;
    logic [3:0]              kind_v;
    logic [1:0]              cnt_v;
    evt_hdr_t                hdr_v  [MAX_EVENTS];
    logic [LINE_BITS-1:0]    lin_v  [MAX_EVENTS];
    logic [OFFSET_BITS-1:0]  pos_v  [MAX_EVENTS];
    logic                    accept;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    always_comb begin
        eof       = in_eoi || (in_data == CH_EOF);
        ch        = eof ? CH_EOF : in_data;
        mode_next = mode_reg;
        esc_next  = esc_reg;
        line_next = line_reg;
        off_next  = (off_reg != '1) ? off_reg + 1'b1 : off_reg;
        tsl_next  = tsl_reg;
        tso_next  = tso_reg;
        again     = 1'b0;
        kind_v    = KIND_SYMBOL;
        cnt_v     = 2'd0;
        for (int i = 0; i < MAX_EVENTS; i++) begin
            hdr_v[i] = '0;
            lin_v[i] = '0;
            pos_v[i] = '0;
        end

        case (mode_reg)
            M_SYMBOL, M_KEYWORD: begin
                kind_v = (mode_reg == M_KEYWORD) ? KIND_KEYWORD : KIND_SYMBOL;
                if (!eof && is_sym(ch)) begin
                    hdr_v[cnt_v] = mk_hdr(EV_CONTENT, kind_v, ch, ERR_NONE);
                end else begin
                    hdr_v[cnt_v] = mk_hdr(EV_END, kind_v, 8'd0, ERR_NONE);
                    again = 1'b1;
                end
                lin_v[cnt_v] = tsl_next;
                pos_v[cnt_v] = tso_next;
                cnt_v = cnt_v + 2'd1;
            end
            M_NUM: begin
                if (!eof && is_digit(ch)) begin
                    hdr_v[cnt_v] = mk_hdr(EV_CONTENT, KIND_NUMERAL, ch, ERR_NONE);
                end else if (!eof && ch == CH_DOT) begin
                    hdr_v[cnt_v] = mk_hdr(EV_CONTENT, KIND_DECIMAL, ch, ERR_NONE);
                    mode_next = M_DEC;
                end else begin
                    hdr_v[cnt_v] = mk_hdr(EV_END, KIND_NUMERAL, 8'd0, ERR_NONE);
                    again = 1'b1;
                end
                lin_v[cnt_v] = tsl_next;
                pos_v[cnt_v] = tso_next;
                cnt_v = cnt_v + 2'd1;
            end
            M_DEC: begin
                if (!eof && is_digit(ch)) begin
                    hdr_v[cnt_v] = mk_hdr(EV_CONTENT, KIND_DECIMAL, ch, ERR_NONE);
                end else begin
                    hdr_v[cnt_v] = mk_hdr(EV_END, KIND_DECIMAL, 8'd0, ERR_NONE);
                    again = 1'b1;
                end
                lin_v[cnt_v] = tsl_next;
                pos_v[cnt_v] = tso_next;
                cnt_v = cnt_v + 2'd1;
            end
            M_HASH: begin
                if (ch == CH_LOW_B || ch == CH_LOW_X) begin
                    hdr_v[cnt_v] = mk_hdr(EV_START,
                                          (ch == CH_LOW_B) ? KIND_BINARY : KIND_HEX,
                                          8'd0, ERR_NONE);
                    lin_v[cnt_v] = tsl_next;
                    pos_v[cnt_v] = tso_next;
                    mode_next = (ch == CH_LOW_B) ? M_BIN1 : M_HEX1;
                end else begin
                    hdr_v[cnt_v] = mk_hdr(EV_ERROR, KIND_LPAREN, ch, ERR_RADIX);
                    lin_v[cnt_v] = line_reg;
                    pos_v[cnt_v] = off_next;
                    mode_next = M_ERROR;
                    esc_next  = 1'b0;
                    again     = eof;
                end
                cnt_v = cnt_v + 2'd1;
            end
            M_BIN1, M_BIN, M_HEX1, M_HEX: begin
                kind_v = (mode_reg == M_BIN1 || mode_reg == M_BIN) ? KIND_BINARY : KIND_HEX;
                if ((kind_v == KIND_BINARY && (ch == CH_ZERO || ch == CH_ONE)) ||
                    (kind_v == KIND_HEX && !eof && is_hex(ch))) begin
                    hdr_v[cnt_v] = mk_hdr(EV_CONTENT, kind_v, ch, ERR_NONE);
                    lin_v[cnt_v] = tsl_next;
                    pos_v[cnt_v] = tso_next;
                    mode_next = (kind_v == KIND_BINARY) ? M_BIN : M_HEX;
                end else if (mode_reg == M_BIN1 || mode_reg == M_HEX1) begin
                    hdr_v[cnt_v] = mk_hdr(EV_ERROR, KIND_LPAREN, ch, ERR_RADIX);
                    lin_v[cnt_v] = line_reg;
                    pos_v[cnt_v] = off_next;
                    mode_next = M_ERROR;
                    esc_next  = 1'b0;
                    again     = eof;
                end else begin
                    hdr_v[cnt_v] = mk_hdr(EV_END, kind_v, 8'd0, ERR_NONE);
                    lin_v[cnt_v] = tsl_next;
                    pos_v[cnt_v] = tso_next;
                    again = 1'b1;
                end
                cnt_v = cnt_v + 2'd1;
            end
            M_QSYM: begin
                if (eof) begin
                    hdr_v[cnt_v] = mk_hdr(EV_ERROR, KIND_LPAREN, ch, ERR_EOF_QSYM);
                    lin_v[cnt_v] = line_reg;
                    pos_v[cnt_v] = off_next;
                    mode_next = M_ERROR;
                    esc_next  = 1'b0;
                    again     = 1'b1;
                end else if (ch == CH_BAR && !esc_reg) begin
                    hdr_v[cnt_v] = mk_hdr(EV_END, KIND_SYMBOL, 8'd0, ERR_NONE);
                    lin_v[cnt_v] = tsl_next;
                    pos_v[cnt_v] = tso_next;
                    mode_next = M_IDLE;
                end else begin
                    hdr_v[cnt_v] = mk_hdr(EV_CONTENT, KIND_SYMBOL, ch, ERR_NONE);
                    lin_v[cnt_v] = tsl_next;
                    pos_v[cnt_v] = tso_next;
                    esc_next = (ch == CH_BSLASH);
                end
                cnt_v = cnt_v + 2'd1;
            end
            M_STRING: begin
                if (eof) begin
                    hdr_v[cnt_v] = mk_hdr(EV_ERROR, KIND_LPAREN, ch, ERR_EOF_STR);
                    lin_v[cnt_v] = line_reg;
                    pos_v[cnt_v] = off_next;
                    cnt_v = cnt_v + 2'd1;
                    mode_next = M_ERROR;
                    esc_next  = 1'b0;
                    again     = 1'b1;
                end else if (esc_reg) begin
                    esc_next = 1'b0;
                    if (ch == CH_BSLASH || ch == CH_QUOTE || ch == CH_LOW_N) begin
                        hdr_v[cnt_v] = mk_hdr(EV_CONTENT, KIND_STRING,
                                              (ch == CH_LOW_N) ? CH_LF : ch, ERR_NONE);
                        lin_v[cnt_v] = tsl_next;
                        pos_v[cnt_v] = tso_next;
                    end else begin
                        hdr_v[cnt_v] = mk_hdr(EV_ERROR, KIND_LPAREN, ch, ERR_ESCAPE);
                        lin_v[cnt_v] = line_reg;
                        pos_v[cnt_v] = off_next;
                        mode_next = M_ERROR;
                    end
                    cnt_v = cnt_v + 2'd1;
                end else if (ch == CH_QUOTE) begin
                    hdr_v[cnt_v] = mk_hdr(EV_END, KIND_STRING, 8'd0, ERR_NONE);
                    lin_v[cnt_v] = tsl_next;
                    pos_v[cnt_v] = tso_next;
                    cnt_v = cnt_v + 2'd1;
                    mode_next = M_IDLE;
                end else if (ch == CH_BSLASH) begin
                    esc_next = 1'b1;
                end else begin
                    hdr_v[cnt_v] = mk_hdr(EV_CONTENT, KIND_STRING, ch, ERR_NONE);
                    lin_v[cnt_v] = tsl_next;
                    pos_v[cnt_v] = tso_next;
                    cnt_v = cnt_v + 2'd1;
                end
            end
            M_COMMENT: begin
                if (eof) begin
                    again = 1'b1;
                end else if (ch == CH_LF) begin
                    mode_next = M_IDLE;
                end
            end
            M_ERROR: begin
                again = eof;
            end
            default: begin
                again = 1'b1;
            end
        endcase

        if (again) begin
            if (eof) begin
                // eof token, then back to the reset state
                hdr_v[cnt_v] = mk_hdr(EV_START, KIND_EOF, 8'd0, ERR_NONE);
                lin_v[cnt_v] = line_reg;
                pos_v[cnt_v] = off_next;
                cnt_v = cnt_v + 2'd1;
                hdr_v[cnt_v] = mk_hdr(EV_END, KIND_EOF, 8'd0, ERR_NONE);
                lin_v[cnt_v] = line_reg;
                pos_v[cnt_v] = off_next;
                cnt_v = cnt_v + 2'd1;
                mode_next = M_IDLE;
                esc_next  = 1'b0;
                line_next = LINE_BITS'(1);
                off_next  = '0;
                tsl_next  = LINE_BITS'(1);
                tso_next  = '0;
            end else begin
                mode_next = M_IDLE;
                esc_next  = 1'b0;
                if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF) begin
                    mode_next = M_IDLE;
                end else if (ch == CH_SEMI) begin
                    mode_next = M_COMMENT;
                end else if (ch == CH_HASH) begin
                    tsl_next  = line_reg;
                    tso_next  = off_next;
                    mode_next = M_HASH;
                end else if (ch == CH_LPAREN || ch == CH_RPAREN) begin
                    tsl_next = line_reg;
                    tso_next = off_next;
                    kind_v   = (ch == CH_LPAREN) ? KIND_LPAREN : KIND_RPAREN;
                    hdr_v[cnt_v] = mk_hdr(EV_START, kind_v, 8'd0, ERR_NONE);
                    lin_v[cnt_v] = tsl_next;
                    pos_v[cnt_v] = tso_next;
                    cnt_v = cnt_v + 2'd1;
                    hdr_v[cnt_v] = mk_hdr(EV_END, kind_v, 8'd0, ERR_NONE);
                    lin_v[cnt_v] = tsl_next;
                    pos_v[cnt_v] = tso_next;
                    cnt_v = cnt_v + 2'd1;
                end else if (ch == CH_BAR || ch == CH_QUOTE) begin
                    tsl_next = line_reg;
                    tso_next = off_next;
                    hdr_v[cnt_v] = mk_hdr(EV_START,
                                          (ch == CH_BAR) ? KIND_SYMBOL : KIND_STRING,
                                          8'd0, ERR_NONE);
                    lin_v[cnt_v] = tsl_next;
                    pos_v[cnt_v] = tso_next;
                    cnt_v = cnt_v + 2'd1;
                    mode_next = (ch == CH_BAR) ? M_QSYM : M_STRING;
                end else if (ch == CH_COLON || is_digit(ch) || is_sym(ch)) begin
                    tsl_next = line_reg;
                    tso_next = off_next;
                    if (ch == CH_COLON) begin
                        kind_v    = KIND_KEYWORD;
                        mode_next = M_KEYWORD;
                    end else if (is_digit(ch)) begin
                        kind_v    = KIND_NUMERAL;
                        mode_next = M_NUM;
                    end else begin
                        kind_v    = KIND_SYMBOL;
                        mode_next = M_SYMBOL;
                    end
                    hdr_v[cnt_v] = mk_hdr(EV_START, kind_v, 8'd0, ERR_NONE);
                    lin_v[cnt_v] = tsl_next;
                    pos_v[cnt_v] = tso_next;
                    cnt_v = cnt_v + 2'd1;
                    hdr_v[cnt_v] = mk_hdr(EV_CONTENT, kind_v, ch, ERR_NONE);
                    lin_v[cnt_v] = tsl_next;
                    pos_v[cnt_v] = tso_next;
                    cnt_v = cnt_v + 2'd1;
                end else begin
                    hdr_v[cnt_v] = mk_hdr(EV_ERROR, KIND_LPAREN, ch, ERR_INVALID);
                    lin_v[cnt_v] = line_reg;
                    pos_v[cnt_v] = off_next;
                    cnt_v = cnt_v + 2'd1;
                    mode_next = M_ERROR;
                end
            end
        end

        // line count advances after the byte, in any mode
        if (!eof && ch == CH_LF && line_next != '1) begin
            line_next = line_next + 1'b1;
        end
    end

    always_comb begin
        push_data[1:0] = cnt_v;
        for (int i = 0; i < MAX_EVENTS; i++) begin
            push_data[2 + i*EVT_BITS +: EVT_BITS] = {pos_v[i], lin_v[i], hdr_v[i]};
        end
    end

    assign push_valid = accept && (cnt_v != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            esc_reg  <= 1'b0;
            line_reg <= LINE_BITS'(1);
            off_reg  <= '0;
            tsl_reg  <= LINE_BITS'(1);
            tso_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            line_reg <= line_next;
            off_reg  <= off_next;
            tsl_reg  <= tsl_next;
            tso_reg  <= tso_next;
        end
    end

    `SLT_ASSERT_ALWAYS(a_line_nonzero, line_reg != '0)
    `SLT_ASSERT_IMPL(a_esc_only_quoted, esc_reg, mode_reg == M_QSYM || mode_reg == M_STRING)

endmodule

// File: design/slt_queue.sv
// Short bundle queue between the front and back ends.
// Depends on slt_pkg for the default depth.
`include "smt_lib_tokenizer_assert.svh"
module slt_queue
    import slt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                push, pop;

    assign wr_ready = (count_reg != CNT_BITS'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `SLT_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_BITS'(DEPTH))
    `SLT_ASSERT_NEXT(a_count_drop, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

// File: design/slt_back.sv
// Back end: holds one bundle and hands out its events one transfer at a time.
// Depends on slt_pkg for the event header layout.
`include "smt_lib_tokenizer_assert.svh"
module slt_back
    import slt_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    localparam int EVT_BITS   = HDR_BITS + LINE_BITS + OFFSET_BITS,
    localparam int BUNDLE_BITS = 2 + MAX_EVENTS * EVT_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  logic [BUNDLE_BITS-1:0] q_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output evt_hdr_t               out_hdr,
    output logic [LINE_BITS-1:0]   out_line,
    output logic [OFFSET_BITS-1:0] out_offset,
    output logic                   out_last
);

    logic [BUNDLE_BITS-1:0] bundle_reg;
    logic                   valid_reg;
    logic [1:0]             idx_reg;
    logic [1:0]             cnt;
    logic [EVT_BITS-1:0]    cur;
    logic                   take;

    assign cnt = bundle_reg[1:0];

    always_comb begin
        case (idx_reg)
            2'd1:    cur = bundle_reg[2 + EVT_BITS +: EVT_BITS];
            2'd2:    cur = bundle_reg[2 + 2*EVT_BITS +: EVT_BITS];
            default: cur = bundle_reg[2 +: EVT_BITS];
        endcase
    end

    assign out_hdr    = evt_hdr_t'(cur[HDR_BITS-1:0]);
    assign out_line   = cur[HDR_BITS +: LINE_BITS];
    assign out_offset = cur[HDR_BITS + LINE_BITS +: OFFSET_BITS];
    assign out_last   = (idx_reg == cnt - 2'd1);
    assign out_valid  = valid_reg;

    // load the next bundle when empty or when its last event leaves
    assign take    = !valid_reg || (out_ready && out_last);
    assign q_ready = take;

    always_ff @(posedge aclk) begin
        if (take && q_valid) begin
            bundle_reg <= q_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (take) begin
            valid_reg <= q_valid;
            idx_reg   <= 2'd0;
        end else if (out_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    `SLT_ASSERT_IMPL(a_idx_in_bundle, valid_reg, cnt != 2'd0 && idx_reg < cnt)

endmodule

// File: design/smt_lib_tokenizer.sv
// Top level of the SMT-LIB2 tokenizer: byte stream in, token event stream out.
// Depends on slt_pkg, slt_front, slt_queue and slt_back.
//
// The tokenizer takes one source byte per transfer and produces zero to three
// events per byte (token start, content byte, token end, error), each with the
// token kind, the line and the one-based offset where the token starts (for
// errors, where the offending byte sits). A byte of 0xFF or tlast on the input
// marks end of input: any complete open token is closed, an open string,
// quoted symbol or radix prefix reports its error, an eof token follows and
// the counters return to their reset values for the next stream. After an
// error the block emits nothing until end of input. Line and offset counters
// saturate. The front end classifies a byte in the cycle it arrives and
// writes its events as one bundle into a QUEUE_DEPTH-entry queue; the back
// end sends one event per cycle while the result port is ready, with tlast
// on the last event of each byte. A byte that yields no event writes no
// bundle; input is taken every cycle while the queue has room, so the
// sustained rate is one byte per cycle as long as the bytes average at most
// one event, and otherwise one event per cycle at the result port. Between
// input transfer and first result lie the queue entry and the bundle register.
module smt_lib_tokenizer
    import slt_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int M_FIELD_BITS = 11 + LINE_BITS + OFFSET_BITS,
    localparam int M_DATA_W     = ((M_FIELD_BITS + 7) / 8) * 8,
    localparam int EVT_BITS     = HDR_BITS + LINE_BITS + OFFSET_BITS,
    localparam int BUNDLE_BITS  = 2 + MAX_EVENTS * EVT_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
    input  logic                s_axis_tlast,   // end_of_input
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // content_byte, error_code, line_number, byte_offset (lowest bit up), zero fill
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic [5:0]          m_axis_tuser,   // event_res [1:0], token_kind [5:2]
    output logic                m_axis_tlast    // last event caused by the input byte
);

    logic                   push_valid, push_ready;
    logic [BUNDLE_BITS-1:0] push_data;
    logic                   pop_valid, pop_ready;
    logic [BUNDLE_BITS-1:0] pop_data;
    evt_hdr_t               evt_hdr;
    logic [LINE_BITS-1:0]   evt_line;
    logic [OFFSET_BITS-1:0] evt_offset;

    // Classify each byte and update the lexer state.
    slt_front #(
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_eoi     (s_axis_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple the two ends so either may stall on its own.
    slt_queue #(
        .WIDTH (BUNDLE_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    // Serialize each bundle into single event transfers.
    slt_back #(
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (pop_valid),
        .q_ready    (pop_ready),
        .q_data     (pop_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_hdr    (evt_hdr),
        .out_line   (evt_line),
        .out_offset (evt_offset),
        .out_last   (m_axis_tlast)
    );

    // Pack the result fields, zero fill to whole bytes.
    assign m_axis_tdata = M_DATA_W'({evt_offset, evt_line, evt_hdr.err, evt_hdr.data});
    assign m_axis_tuser = {evt_hdr.kind, evt_hdr.ev};

endmodule

// File: tb/smt_lib_tokenizer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for smt_lib_tokenizer: byte stream in, token events out.
// Depends on slt_pkg and the smt_lib_tokenizer RTL; a built-in lexer predicts every event.
module smt_lib_tokenizer_tb
    import slt_pkg::*;
();

    // Result bus width for the default line and offset widths: 67 bits of fields, byte filled.
    localparam int DATA_W = ((11 + LINE_BITS_DEF + OFFSET_BITS_DEF + 7) / 8) * 8;
    // The kind field carries zero on error events.
    localparam logic [3:0] NO_KIND = 4'd0;
    // Total input bytes, directed and random together.
    localparam int STOP_ITEMS = 470;

    // One token event as the result channel carries it.
    typedef struct packed {
        logic [1:0]  ev;
        logic [3:0]  kind;
        logic [7:0]  data;
        logic [2:0]  err;
        logic [23:0] lnum;
        logic [31:0] offs;
        logic        last;
    } tok_event_t;

    typedef struct packed {
        logic [7:0] b;
        logic       tl;
    } src_byte_t;

    // A directed row: the byte, its end-of-input flag and, where typed, the first event.
    typedef struct {
        logic [7:0]  b;
        logic        tl;
        logic        typed;
        logic [1:0]  ev;
        logic [3:0]  kind;
        logic [7:0]  data;
        logic [2:0]  err;
        logic [23:0] lnum;
        logic [31:0] offs;
    } dir_row_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = 8'h00;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [5:0]        m_axis_tuser;
    logic              m_axis_tlast;

    // Lexer state of the predictor.
    mode_t       lx_mode;
    logic        esc;
    logic [23:0] line_cnt;
    logic [31:0] off_cnt;
    logic [23:0] tok_line;
    logic [31:0] tok_off;

    tok_event_t step_evs[$];         // events caused by the byte being predicted
    tok_event_t expected_events[$];  // events still owed by the block
    src_byte_t  src_q[$];            // bytes of the random text not yet sent

    dir_row_t dir_rows[31];

    logic calm = 1'b0;  // no idling on either side while set
    int   mismatch_cnt   = 0;
    int   live_items     = 0;
    int   bytes_sent     = 0;
    int   events_checked = 0;
    int   streams_closed = 0;
    int   errors_seen    = 0;

    always #5 aclk = ~aclk;

    smt_lib_tokenizer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic logic digit_ch(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic hex_ch(input logic [7:0] c);
        return digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic sym_ch(input logic [7:0] c);
        if (digit_ch(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
            return 1'b1;
        case (c)
            "~", "!", "@", "$", "%", "^", "&", "*", "_", "-", "+", "=", "<", ">",
            CH_DOT, "?": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Lexer predictor
    // ------------------------------------------------------------------
    task automatic lex_reset();
        lx_mode  = M_IDLE;
        esc      = 1'b0;
        line_cnt = 24'd1;
        off_cnt  = 32'd0;
        tok_line = 24'd1;
        tok_off  = 32'd0;
    endtask

    task automatic add_event(input logic [1:0] ev, input logic [3:0] kind, input logic [7:0] data,
                             input logic [2:0] err, input logic [23:0] lnum,
                             input logic [31:0] offs);
        // at most three events per byte
        if (step_evs.size() < MAX_EVENTS)
            step_evs.push_back('{ev, kind, data, err, lnum, offs, 1'b0});
    endtask

    task automatic token_event(input logic [1:0] ev, input logic [3:0] kind,
                               input logic [7:0] data);
        add_event(ev, kind, data, ERR_NONE, tok_line, tok_off);
    endtask

    task automatic open_token(input logic [3:0] kind);
        tok_line = line_cnt;
        tok_off  = off_cnt;
        token_event(EV_START, kind, 8'h00);
    endtask

    // Errors report where the offending byte sits, then silence until end of input.
    task automatic flag_error(input logic [2:0] code, input logic [7:0] c);
        add_event(EV_ERROR, NO_KIND, c, code, line_cnt, off_cnt);
        lx_mode = M_ERROR;
        esc     = 1'b0;
    endtask

    task automatic lex_idle(input logic [7:0] c, input logic eof);
        if (eof) begin
            // eof token, then back to the reset state for the next stream
            open_token(KIND_EOF);
            token_event(EV_END, KIND_EOF, 8'h00);
            lex_reset();
        end else begin
            lx_mode = M_IDLE;
            esc     = 1'b0;
            case (c)
                CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
                CH_SEMI: lx_mode = M_COMMENT;
                CH_LPAREN: begin
                    open_token(KIND_LPAREN);
                    token_event(EV_END, KIND_LPAREN, 8'h00);
                end
                CH_RPAREN: begin
                    open_token(KIND_RPAREN);
                    token_event(EV_END, KIND_RPAREN, 8'h00);
                end
                CH_COLON: begin
                    open_token(KIND_KEYWORD);
                    token_event(EV_CONTENT, KIND_KEYWORD, c);
                    lx_mode = M_KEYWORD;
                end
                CH_BAR: begin
                    open_token(KIND_SYMBOL);
                    lx_mode = M_QSYM;
                end
                CH_QUOTE: begin
                    open_token(KIND_STRING);
                    lx_mode = M_STRING;
                end
                CH_HASH: begin
                    // remember where the prefix began; nothing is emitted yet
                    tok_line = line_cnt;
                    tok_off  = off_cnt;
                    lx_mode  = M_HASH;
                end
                default: begin
                    if (digit_ch(c)) begin
                        open_token(KIND_NUMERAL);
                        token_event(EV_CONTENT, KIND_NUMERAL, c);
                        lx_mode = M_NUM;
                    end else if (sym_ch(c)) begin
                        open_token(KIND_SYMBOL);
                        token_event(EV_CONTENT, KIND_SYMBOL, c);
                        lx_mode = M_SYMBOL;
                    end else begin
                        flag_error(ERR_INVALID, c);
                    end
                end
            endcase
        end
    endtask

    // Advance the predictor by one input byte and leave its events in step_evs.
    task automatic tokenize_byte(input logic [7:0] b, input logic tl);
        logic       eof;
        logic       redo;
        logic       nl;
        logic [7:0] c;
        logic [3:0] k;
        tok_event_t e;
        eof  = tl || (b == CH_EOF);
        c    = eof ? CH_EOF : b;
        nl   = !eof && (c == CH_LF);
        redo = 1'b0;
        step_evs.delete();
        if (off_cnt != '1)
            off_cnt = off_cnt + 32'd1;
        case (lx_mode)
            M_SYMBOL, M_KEYWORD: begin
                k = (lx_mode == M_KEYWORD) ? KIND_KEYWORD : KIND_SYMBOL;
                if (!eof && sym_ch(c)) begin
                    token_event(EV_CONTENT, k, c);
                end else begin
                    token_event(EV_END, k, 8'h00);
                    redo = 1'b1;
                end
            end
            M_NUM: begin
                if (!eof && digit_ch(c)) begin
                    token_event(EV_CONTENT, KIND_NUMERAL, c);
                end else if (!eof && c == CH_DOT) begin
                    // the dot turns the numeral into a decimal
                    token_event(EV_CONTENT, KIND_DECIMAL, c);
                    lx_mode = M_DEC;
                end else begin
                    token_event(EV_END, KIND_NUMERAL, 8'h00);
                    redo = 1'b1;
                end
            end
            M_DEC: begin
                if (!eof && digit_ch(c)) begin
                    token_event(EV_CONTENT, KIND_DECIMAL, c);
                end else begin
                    token_event(EV_END, KIND_DECIMAL, 8'h00);
                    redo = 1'b1;
                end
            end
            M_HASH: begin
                if (c == CH_LOW_B) begin
                    token_event(EV_START, KIND_BINARY, 8'h00);
                    lx_mode = M_BIN1;
                end else if (c == CH_LOW_X) begin
                    token_event(EV_START, KIND_HEX, 8'h00);
                    lx_mode = M_HEX1;
                end else begin
                    flag_error(ERR_RADIX, c);
                    redo = eof;
                end
            end
            M_BIN1, M_BIN: begin
                if (c == CH_ZERO || c == CH_ONE) begin
                    token_event(EV_CONTENT, KIND_BINARY, c);
                    lx_mode = M_BIN;
                end else if (lx_mode == M_BIN1) begin
                    flag_error(ERR_RADIX, c);
                    redo = eof;
                end else begin
                    token_event(EV_END, KIND_BINARY, 8'h00);
                    redo = 1'b1;
                end
            end
            M_HEX1, M_HEX: begin
                if (!eof && hex_ch(c)) begin
                    token_event(EV_CONTENT, KIND_HEX, c);
                    lx_mode = M_HEX;
                end else if (lx_mode == M_HEX1) begin
                    flag_error(ERR_RADIX, c);
                    redo = eof;
                end else begin
                    token_event(EV_END, KIND_HEX, 8'h00);
                    redo = 1'b1;
                end
            end
            M_QSYM: begin
                if (eof) begin
                    flag_error(ERR_EOF_QSYM, c);
                    redo = 1'b1;
                end else if (c == CH_BAR && !esc) begin
                    token_event(EV_END, KIND_SYMBOL, 8'h00);
                    lx_mode = M_IDLE;
                end else begin
                    // everything between the bars is content, an escaped bar too
                    token_event(EV_CONTENT, KIND_SYMBOL, c);
                    esc = (c == CH_BSLASH);
                end
            end
            M_STRING: begin
                if (eof) begin
                    flag_error(ERR_EOF_STR, c);
                    redo = 1'b1;
                end else if (esc) begin
                    esc = 1'b0;
                    if (c == CH_BSLASH || c == CH_QUOTE)
                        token_event(EV_CONTENT, KIND_STRING, c);
                    else if (c == CH_LOW_N)
                        token_event(EV_CONTENT, KIND_STRING, CH_LF);
                    else
                        flag_error(ERR_ESCAPE, c);
                end else if (c == CH_QUOTE) begin
                    token_event(EV_END, KIND_STRING, 8'h00);
                    lx_mode = M_IDLE;
                end else if (c == CH_BSLASH) begin
                    esc = 1'b1;
                end else begin
                    token_event(EV_CONTENT, KIND_STRING, c);
                end
            end
            M_COMMENT: begin
                if (eof)
                    redo = 1'b1;
                else if (c == CH_LF)
                    lx_mode = M_IDLE;
            end
            M_ERROR: begin
                if (eof)
                    redo = 1'b1;
            end
            default: redo = 1'b1;
        endcase
        // a terminating byte is handled again as in idle
        if (redo)
            lex_idle(c, eof);
        if (nl && line_cnt != '1)
            line_cnt = line_cnt + 24'd1;
        if (step_evs.size() > 0) begin
            e           = step_evs[$];
            e.last      = 1'b1;
            step_evs[$] = e;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Offer one byte, hold it until the transfer, then queue what it must produce.
    // On a typed row the first event comes from the table instead of the predictor.
    task automatic send_byte(input logic [7:0] b, input logic tl, input logic typed,
                             input tok_event_t want);
        tok_event_t e;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= tl;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        if (lx_mode != M_COMMENT && lx_mode != M_ERROR)
            live_items++;
        bytes_sent++;
        tokenize_byte(b, tl);
        if (typed && step_evs.size() > 0) begin
            e        = want;
            e.last   = step_evs[0].last;
            step_evs[0] = e;
        end
        foreach (step_evs[i])
            expected_events.push_back(step_evs[i]);
        // idle the input now and then, but never inside the calm stretch
        if (!calm && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (expected_events.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Random text: mostly well-formed tokens with random content, some noise
    // ------------------------------------------------------------------
    task automatic push_src(input logic [7:0] b, input logic tl);
        src_q.push_back('{b, tl});
    endtask

    function automatic logic [7:0] rand_sym();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        while (!sym_ch(c))
            c = 8'($urandom_range(33, 126));
        return c;
    endfunction

    function automatic logic [7:0] rand_hex();
        logic [7:0] c;
        c = 8'($urandom_range(48, 102));
        while (!hex_ch(c))
            c = 8'($urandom_range(48, 102));
        return c;
    endfunction

    task automatic queue_word();
        int         pick;
        int         r;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 10) begin
            push_src($urandom_range(1) ? CH_LPAREN : CH_RPAREN, 1'b0);
        end else if (pick < 25) begin
            repeat ($urandom_range(1, 6)) push_src(rand_sym(), 1'b0);
        end else if (pick < 32) begin
            push_src(CH_COLON, 1'b0);
            repeat ($urandom_range(0, 5)) push_src(rand_sym(), 1'b0);
        end else if (pick < 42) begin
            repeat ($urandom_range(1, 4)) push_src(CH_ZERO + 8'($urandom_range(9)), 1'b0);
            if ($urandom_range(1)) begin
                push_src(CH_DOT, 1'b0);
                repeat ($urandom_range(0, 3)) push_src(CH_ZERO + 8'($urandom_range(9)), 1'b0);
            end
        end else if (pick < 48) begin
            push_src(CH_HASH, 1'b0);
            push_src(CH_LOW_X, 1'b0);
            repeat ($urandom_range(1, 4)) push_src(rand_hex(), 1'b0);
        end else if (pick < 53) begin
            push_src(CH_HASH, 1'b0);
            push_src(CH_LOW_B, 1'b0);
            repeat ($urandom_range(1, 6)) push_src(CH_ZERO + 8'($urandom_range(1)), 1'b0);
        end else if (pick < 60) begin
            // quoted symbol, with escapes that may hide a bar
            push_src(CH_BAR, 1'b0);
            repeat ($urandom_range(0, 5)) begin
                c = ($urandom_range(3) == 0) ? CH_BSLASH : 8'($urandom_range(254));
                if (c == CH_BAR)
                    c = CH_BSLASH;
                push_src(c, 1'b0);
                if (c == CH_BSLASH)
                    push_src($urandom_range(1) ? CH_BAR : 8'($urandom_range(254)), 1'b0);
            end
            push_src(CH_BAR, 1'b0);
        end else if (pick < 69) begin
            // string with good escapes and the odd bad one
            push_src(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 5)) begin
                r = $urandom_range(9);
                if (r < 2) begin
                    push_src(CH_BSLASH, 1'b0);
                    case ($urandom_range(2))
                        0: push_src(CH_BSLASH, 1'b0);
                        1: push_src(CH_QUOTE, 1'b0);
                        default: push_src(CH_LOW_N, 1'b0);
                    endcase
                end else if (r == 2 && $urandom_range(3) == 0) begin
                    push_src(CH_BSLASH, 1'b0);
                    push_src(8'($urandom_range(254)), 1'b0);
                end else begin
                    c = 8'($urandom_range(254));
                    if (c == CH_QUOTE || c == CH_BSLASH)
                        c = "a";
                    push_src(c, 1'b0);
                end
            end
            push_src(CH_QUOTE, 1'b0);
        end else if (pick < 73) begin
            push_src(CH_SEMI, 1'b0);
            repeat ($urandom_range(0, 4)) begin
                c = 8'($urandom_range(254));
                push_src((c == CH_LF) ? CH_SPACE : c, 1'b0);
            end
            push_src(CH_LF, 1'b0);
        end else if (pick < 83) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(3))
                    0: push_src(CH_SPACE, 1'b0);
                    1: push_src(CH_TAB, 1'b0);
                    2: push_src(CH_CR, 1'b0);
                    default: push_src(CH_LF, 1'b0);
                endcase
            end
        end else if (pick < 89) begin
            // end of input, flagged by tlast or by the 0xFF byte
            if ($urandom_range(1))
                push_src(8'($urandom_range(255)), 1'b1);
            else
                push_src(CH_EOF, 1'b0);
        end else begin
            case ($urandom_range(2))
                0: push_src(8'($urandom_range(255)), 1'b0);
                1: begin
                    push_src(CH_HASH, 1'b0);
                    push_src(8'($urandom_range(255)), 1'b0);
                end
                default: begin
                    // token cut off by end of input
                    case ($urandom_range(3))
                        0: push_src(CH_BAR, 1'b0);
                        1: push_src(CH_QUOTE, 1'b0);
                        2: push_src(CH_HASH, 1'b0);
                        default: begin
                            push_src(CH_HASH, 1'b0);
                            push_src($urandom_range(1) ? CH_LOW_B : CH_LOW_X, 1'b0);
                        end
                    endcase
                    push_src(8'($urandom_range(255)), 1'b1);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 30);
    end

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        tok_event_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event, tuser %0h tdata %0h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatch_cnt++;
            end else begin
                want = expected_events.pop_front();
                events_checked++;
                if (want.ev == EV_ERROR)
                    errors_seen++;
                if (want.ev == EV_END && want.kind == KIND_EOF)
                    streams_closed++;
                check_field("event", want.ev, m_axis_tuser[1:0]);
                check_field("kind", want.kind, m_axis_tuser[5:2]);
                check_field("content", want.data, m_axis_tdata[7:0]);
                check_field("error code", want.err, m_axis_tdata[10:8]);
                check_field("line", want.lnum, m_axis_tdata[34:11]);
                check_field("offset", want.offs, m_axis_tdata[66:35]);
                check_field("fill", 32'd0, m_axis_tdata[DATA_W-1:67]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        src_byte_t  s;
        tok_event_t want;
        logic       paused;
        paused = 1'b0;
        lex_reset();
        // Directed text: every token kind except hex, escapes, newlines inside and outside
        // tokens, comments, both end-of-input forms and every error code.
        dir_rows = '{
            '{CH_RPAREN, 1'b0, 1'b1, EV_START, KIND_RPAREN, 8'h00, ERR_NONE, 24'd1, 32'd1},
            '{CH_COLON,  1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{"~",       1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_LPAREN, 1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{"7",       1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_DOT,    1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_NINE,   1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_BAR,    1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_BSLASH, 1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_BAR,    1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_LF,     1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_BAR,    1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_SEMI,   1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{8'hC3,     1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_LF,     1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_QUOTE,  1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_BSLASH, 1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_LOW_N,  1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{8'h00,     1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{8'h41,     1'b1, 1'b1, EV_ERROR, NO_KIND, CH_EOF, ERR_EOF_STR, 24'd3, 32'd20},
            '{CH_HASH,   1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_LOW_B,  1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{"2",       1'b0, 1'b1, EV_ERROR, NO_KIND, "2", ERR_RADIX, 24'd1, 32'd3},
            '{CH_EOF,    1'b0, 1'b1, EV_START, KIND_EOF, 8'h00, ERR_NONE, 24'd1, 32'd4},
            '{CH_BAR,    1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{8'h3C,     1'b1, 1'b1, EV_ERROR, NO_KIND, CH_EOF, ERR_EOF_QSYM, 24'd1, 32'd2},
            '{8'h80,     1'b0, 1'b1, EV_ERROR, NO_KIND, 8'h80, ERR_INVALID, 24'd1, 32'd1},
            '{CH_EOF,    1'b0, 1'b1, EV_START, KIND_EOF, 8'h00, ERR_NONE, 24'd1, 32'd2},
            '{CH_QUOTE,  1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{CH_BSLASH, 1'b0, 1'b0, EV_START, NO_KIND, 8'h00, ERR_NONE, 24'd0, 32'd0},
            '{"q",       1'b0, 1'b1, EV_ERROR, NO_KIND, "q", ERR_ESCAPE, 24'd1, 32'd3}
        };

        // hold reset, then release it once
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            want = '{dir_rows[i].ev, dir_rows[i].kind, dir_rows[i].data, dir_rows[i].err,
                     dir_rows[i].lnum, dir_rows[i].offs, 1'b0};
            send_byte(dir_rows[i].b, dir_rows[i].tl, dir_rows[i].typed, want);
        end

        // random text; one calm stretch, and one pause that lets the block drain
        want = '0;
        while (bytes_sent < STOP_ITEMS) begin
            if (src_q.size() == 0)
                queue_word();
            calm = (bytes_sent >= 150) && (bytes_sent < 240);
            if (!paused && bytes_sent >= 300) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                paused = 1'b1;
            end
            s = src_q.pop_front();
            send_byte(s.b, s.tl, 1'b0, want);
        end

        // drop valid, drain, then let the clock run on before the summary
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);

        $display("Streamed %0d bytes (%0d outside comments and error recovery), checked %0d events",
                 bytes_sent, live_items, events_checked);
        $display("Closed %0d streams, saw %0d error events, %0d mismatches",
                 streams_closed, errors_seen, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: a correct run needs far less than this.
    initial begin
        #2_000_000;
        $display("%0t: run did not complete, %0d events still expected",
                 $time, expected_events.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
